/* hw/rtl/spim_pkg.sv */
// shared types and constants for the spi master burst transfer unit
// no dependencies; imported by every module of the block but spim_checker
`default_nettype none

package spim_pkg;

   // bits in one spi byte
   localparam int unsigned BYTE_BITS = 8;
   localparam int unsigned BIT_CNT_W = 4;
   // address byte bit that marks a write burst
   localparam int unsigned ADDR_WRITE_BIT = BYTE_BITS - 1;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_RD    = 2'd1,
      CMD_WR    = 2'd2,
      CMD_LOAD  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_ADDR = 2'd1,
      MODE_RD   = 2'd2,
      MODE_WR   = 2'd3
   } mode_type;

   // one request word
   typedef struct packed {
      cmd_type               cmd;
      logic [BYTE_BITS-1:0]  address;
      logic [7:0]            burst_length;
      logic [BYTE_BITS-1:0]  wr_data;
      logic                  miso;
   } req_type;

   // one response word
   typedef struct packed {
      logic                  sclk;
      logic                  mosi;
      logic                  cs_n;
      logic [BYTE_BITS-1:0]  rd_data;
      logic                  rd_valid;
      logic                  wants_byte;
      logic                  busy_res;
      logic                  burst_done;
      logic                  rejected;
   } rsp_type;

   // sequencer state
   typedef struct packed {
      mode_type              mode;
      logic                  is_write;
      logic                  half_phase;
      logic [BIT_CNT_W-1:0]  bits_left;
      logic [BYTE_BITS-1:0]  shift_reg;
      logic [7:0]            bytes_left;
      logic                  sclk_level;
      logic                  mosi_level;
      logic                  cs_level;
   } seq_state_type;

   // handshake between the stages
   typedef struct packed {
      logic                  advance;
   } stage_ctl_type;

endpackage

`default_nettype wire

/* hw/rtl/spim_in_stage.sv */
// input register stage: holds one accepted request word
// depends on spim_pkg
`default_nettype none

module spim_in_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire spim_pkg::req_type req_item,
   input  wire logic            advance,
   output spim_pkg::req_type    item_ff,
   output logic                 valid_ff
);
   import spim_pkg::*;

   logic    valid_in;
   logic    accept;
   req_type item_in;

   // stall only while a held word cannot move on
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // next contents of the input register
   always_comb begin
      item_in  = accept ? req_item : item_ff;
      valid_in = accept || (valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/spim_core.sv */
// burst sequencer: state registers and the per-word step logic
// depends on spim_pkg
`default_nettype none

module spim_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire spim_pkg::req_type item,
   input  wire logic              advance,
   output spim_pkg::rsp_type      result
);
   import spim_pkg::*;

   seq_state_type          st_ff;
   seq_state_type          st_in;
   logic [BIT_CNT_W-1:0]   bits_dec;
   logic [BYTE_BITS-1:0]   shifted;
   logic [7:0]             bytes_dec;
   logic                   waiting;

   assign bits_dec  = st_ff.bits_left - BIT_CNT_W'(1);
   assign bytes_dec = st_ff.bytes_left - 8'd1;
   assign shifted   = {st_ff.shift_reg[BYTE_BITS-2:0],
                       (st_ff.mode == MODE_RD) ? item.miso : 1'b0};
   assign waiting   = (st_ff.mode == MODE_WR) && (st_ff.bits_left == '0)
                      && !st_ff.half_phase;

   // step logic for one word
   always_comb begin
      st_in           = st_ff;
      result          = '0;
      unique case (item.cmd)
         CMD_RD, CMD_WR: begin
            if (st_ff.mode == MODE_IDLE) begin
               if (item.burst_length <= 8'd1) begin
                  result.rejected = 1'b1;
               end else begin
                  st_in.is_write   = (item.cmd == CMD_WR);
                  st_in.mode       = MODE_ADDR;
                  st_in.shift_reg  = item.address;
                  st_in.shift_reg[ADDR_WRITE_BIT] = item.address[ADDR_WRITE_BIT]
                                                    | (item.cmd == CMD_WR);
                  st_in.bits_left  = BIT_CNT_W'(BYTE_BITS);
                  st_in.half_phase = 1'b0;
                  st_in.bytes_left = item.burst_length;
                  st_in.cs_level   = 1'b0;
                  st_in.sclk_level = 1'b0;
               end
            end
         end
         CMD_LOAD: begin
            if (waiting) begin
               st_in.shift_reg  = item.wr_data;
               st_in.bits_left  = BIT_CNT_W'(BYTE_BITS);
               st_in.half_phase = 1'b0;
            end
         end
         CMD_TICK: begin
            if (st_ff.mode != MODE_IDLE) begin
               if (st_ff.bits_left != '0) begin
                  if (!st_ff.half_phase) begin
                     // sclk low half: set mosi
                     st_in.sclk_level = 1'b0;
                     st_in.mosi_level = (st_ff.mode == MODE_RD)
                                        ? 1'b1 : st_ff.shift_reg[BYTE_BITS-1];
                     st_in.half_phase = 1'b1;
                  end else begin
                     // sclk high half: shift and count the bit
                     st_in.sclk_level = 1'b1;
                     st_in.shift_reg  = shifted;
                     st_in.bits_left  = bits_dec;
                     if (bits_dec != '0) begin
                        st_in.half_phase = 1'b0;
                     end else if (st_ff.mode == MODE_RD) begin
                        result.rd_valid = 1'b1;
                        result.rd_data  = shifted;
                     end
                  end
               end else if (st_ff.half_phase) begin
                  // closing tick of a byte
                  st_in.sclk_level = 1'b0;
                  st_in.mosi_level = 1'b1;
                  st_in.half_phase = 1'b0;
                  if (st_ff.mode == MODE_ADDR) begin
                     st_in.mode = st_ff.is_write ? MODE_WR : MODE_RD;
                  end else begin
                     st_in.bytes_left = bytes_dec;
                  end
                  if (st_in.mode != MODE_ADDR && st_in.bytes_left == 8'd0) begin
                     st_in.mode        = MODE_IDLE;
                     st_in.cs_level    = 1'b1;
                     result.burst_done = 1'b1;
                  end else if (st_in.mode == MODE_RD) begin
                     st_in.shift_reg = '0;
                     st_in.bits_left = BIT_CNT_W'(BYTE_BITS);
                  end
               end
            end
         end
         default: begin
         end
      endcase
      // pin levels and status after the step
      result.sclk       = st_in.sclk_level;
      result.mosi       = st_in.mosi_level;
      result.cs_n       = st_in.cs_level;
      result.wants_byte = (st_in.mode == MODE_WR) && (st_in.bits_left == '0)
                          && !st_in.half_phase;
      result.busy_res   = (st_in.mode != MODE_IDLE);
   end

   // state commits when the word moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.mode       <= MODE_IDLE;
         st_ff.is_write   <= 1'b0;
         st_ff.half_phase <= 1'b0;
         st_ff.bits_left  <= '0;
         st_ff.shift_reg  <= '0;
         st_ff.bytes_left <= '0;
         st_ff.sclk_level <= 1'b0;
         st_ff.mosi_level <= 1'b1;
         st_ff.cs_level   <= 1'b1;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/spim_out_stage.sv */
// result register stage: holds one response word until taken
// depends on spim_pkg
`default_nettype none

module spim_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire spim_pkg::rsp_type result,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output spim_pkg::rsp_type      rsp_item,
   output spim_pkg::stage_ctl_type ctl
);
   import spim_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type item_ff;
   rsp_type item_in;

   // a word moves in when the register is empty or being taken
   assign ctl.advance = in_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      item_in  = ctl.advance ? result : item_ff;
      valid_in = ctl.advance || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire

/* hw/rtl/spi_master_burst_transfer_unit.sv */
// spi master burst transfer unit, top level
// an accepted word waits in the input register and steps into the result register when that is free
// throughput: one word per cycle while rsp_stall is low; the step between
//   the input register and the result register is combinational
// reset: synchronous, active high; clears valids, idles the sequencer with
//   cs_n and mosi high and sclk low
`default_nettype none

module spi_master_burst_transfer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_address,
   input  wire logic [7:0]  req_burst_length,
   input  wire logic [7:0]  req_wr_data,
   input  wire logic        req_miso,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_sclk,
   output logic             rsp_mosi,
   output logic             rsp_cs_n,
   output logic [7:0]       rsp_rd_data,
   output logic             rsp_rd_valid,
   output logic             rsp_wants_byte,
   output logic             rsp_busy_res,
   output logic             rsp_burst_done,
   output logic             rsp_rejected
);
   import spim_pkg::*;

   req_type       req_item;
   req_type       held_item;
   logic          held_valid;
   rsp_type       step_result;
   rsp_type       rsp_item;
   stage_ctl_type ctl;

   // gather request ports into one word
   assign req_item.cmd          = cmd_type'(req_cmd);
   assign req_item.address      = req_address;
   assign req_item.burst_length = req_burst_length;
   assign req_item.wr_data      = req_wr_data;
   assign req_item.miso         = req_miso;

   spim_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .advance   (ctl.advance),
      .item_ff   (held_item),
      .valid_ff  (held_valid)
   );

   spim_core u_core (
      .clock   (clock),
      .reset   (reset),
      .item    (held_item),
      .advance (ctl.advance),
      .result  (step_result)
   );

   spim_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (held_valid),
      .result    (step_result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .ctl       (ctl)
   );

   // spread the response word onto its ports
   assign rsp_sclk       = rsp_item.sclk;
   assign rsp_mosi       = rsp_item.mosi;
   assign rsp_cs_n       = rsp_item.cs_n;
   assign rsp_rd_data    = rsp_item.rd_data;
   assign rsp_rd_valid   = rsp_item.rd_valid;
   assign rsp_wants_byte = rsp_item.wants_byte;
   assign rsp_busy_res   = rsp_item.busy_res;
   assign rsp_burst_done = rsp_item.burst_done;
   assign rsp_rejected   = rsp_item.rejected;

endmodule

`default_nettype wire

/* hw/rtl/spim_checker.sv */
// port-level checks for the spi master burst transfer unit
// no package dependency; bound to the top level below
`default_nettype none

module spim_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_sclk,
   input wire logic       rsp_cs_n,
   input wire logic       rsp_rd_valid,
   input wire logic       rsp_wants_byte,
   input wire logic       rsp_busy_res,
   input wire logic       rsp_burst_done,
   input wire logic       rsp_rejected
);

   // chip select is low exactly while a burst runs
   a_cs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_busy_res == !rsp_cs_n))
      else $error("cs_n disagrees with busy");

   // end of burst releases chip select
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_burst_done |-> rsp_cs_n && !rsp_busy_res && !rsp_rd_valid)
      else $error("burst_done without released cs");

   // a read byte completes on the sclk high half
   a_rd_sclk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rd_valid |-> rsp_sclk && rsp_busy_res && !rsp_wants_byte)
      else $error("rd_valid outside sclk high");

   // a refused start leaves the block idle
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> !rsp_busy_res && !rsp_burst_done)
      else $error("rejected start while busy");

   // a stalled response word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sclk) && $stable(rsp_cs_n))
      else $error("stalled response changed");

endmodule

bind spi_master_burst_transfer_unit spim_checker u_spim_checker (.*);

`default_nettype wire

/* dv/spi_master_burst_transfer_unit_tb.sv */
// self-checking testbench for the spi master burst transfer unit
// depends on spim_pkg and spi_master_burst_transfer_unit; predicts every response word
`timescale 1ns / 1ps

module spi_master_burst_transfer_unit_tb;
   import spim_pkg::*;

   localparam int RANDOM_WORDS = 1600;
   localparam int HOLD_AT = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES = 8;
   localparam int MAX_PRINTED = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = '0;
   logic [7:0] req_address = '0;
   logic [7:0] req_burst_length = '0;
   logic [7:0] req_wr_data = '0;
   logic req_miso = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_sclk;
   logic rsp_mosi;
   logic rsp_cs_n;
   logic [7:0] rsp_rd_data;
   logic rsp_rd_valid;
   logic rsp_wants_byte;
   logic rsp_busy_res;
   logic rsp_burst_done;
   logic rsp_rejected;

   // words waiting to be driven and pin words waiting to be seen
   req_type queued_requests[$];
   rsp_type expected_pin_words[$];

   seq_state_type pin_model;
   seq_state_type stim_model;
   req_type next_req;
   req_type seen_req;
   rsp_type seen_rsp;
   rsp_type want_rsp;

   logic req_taken = 1'b0;
   int words_in = 0;
   int words_out = 0;
   int total_words = 0;
   int errors = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   logic hold_used = 1'b0;
   int bursts_seen = 0;
   int reads_seen = 0;
   int rejects_seen = 0;

   spi_master_burst_transfer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_address      (req_address),
      .req_burst_length (req_burst_length),
      .req_wr_data      (req_wr_data),
      .req_miso         (req_miso),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sclk         (rsp_sclk),
      .rsp_mosi         (rsp_mosi),
      .rsp_cs_n         (rsp_cs_n),
      .rsp_rd_data      (rsp_rd_data),
      .rsp_rd_valid     (rsp_rd_valid),
      .rsp_wants_byte   (rsp_wants_byte),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_burst_done   (rsp_burst_done),
      .rsp_rejected     (rsp_rejected)
   );

   always #6 clock = ~clock;

   // sequencer state right after reset
   function automatic seq_state_type idle_state();
      seq_state_type s;
      s = '0;
      s.mode = MODE_IDLE;
      s.mosi_level = 1'b1;
      s.cs_level = 1'b1;
      return s;
   endfunction

   function automatic logic waiting_for_load(input seq_state_type s);
      return (s.mode == MODE_WR) && (s.bits_left == 0) && !s.half_phase;
   endfunction

   // one step of the pin sequencer for one request word (start, load or half-bit tick), returns the pin word
   function automatic rsp_type advance_pins(inout seq_state_type s, input req_type r);
      rsp_type o;
      o = '0;
      case (r.cmd)
         CMD_RD, CMD_WR: begin
            // a start only counts when idle; short bursts are refused
            if (s.mode == MODE_IDLE) begin
               if (r.burst_length <= 8'd1) begin
                  o.rejected = 1'b1;
               end else begin
                  s.is_write = (r.cmd == CMD_WR);
                  s.mode = MODE_ADDR;
                  s.shift_reg = r.address;
                  if (s.is_write) s.shift_reg[ADDR_WRITE_BIT] = 1'b1;
                  s.bits_left = BIT_CNT_W'(BYTE_BITS);
                  s.half_phase = 1'b0;
                  s.bytes_left = r.burst_length;
                  s.cs_level = 1'b0;
                  s.sclk_level = 1'b0;
               end
            end
         end
         CMD_LOAD: begin
            if (waiting_for_load(s)) begin
               s.shift_reg = r.wr_data;
               s.bits_left = BIT_CNT_W'(BYTE_BITS);
               s.half_phase = 1'b0;
            end
         end
         default: begin
            if (s.mode != MODE_IDLE) begin
               if (s.bits_left != 0) begin
                  if (!s.half_phase) begin
                     // sclk low, set up mosi
                     s.sclk_level = 1'b0;
                     s.mosi_level = (s.mode == MODE_RD) ? 1'b1 : s.shift_reg[BYTE_BITS-1];
                     s.half_phase = 1'b1;
                  end else begin
                     // sclk high, shift and sample
                     s.sclk_level = 1'b1;
                     s.shift_reg = {s.shift_reg[BYTE_BITS-2:0],
                                    (s.mode == MODE_RD) ? r.miso : 1'b0};
                     s.bits_left = s.bits_left - 1'b1;
                     if (s.bits_left != 0) begin
                        s.half_phase = 1'b0;
                     end else if (s.mode == MODE_RD) begin
                        o.rd_valid = 1'b1;
                        o.rd_data = s.shift_reg;
                     end
                  end
               end else if (s.half_phase) begin
                  // closing tick of a byte
                  s.sclk_level = 1'b0;
                  s.mosi_level = 1'b1;
                  s.half_phase = 1'b0;
                  if (s.mode == MODE_ADDR) begin
                     s.mode = s.is_write ? MODE_WR : MODE_RD;
                  end else begin
                     s.bytes_left = s.bytes_left - 8'd1;
                  end
                  if (s.mode != MODE_ADDR && s.bytes_left == 0) begin
                     s.mode = MODE_IDLE;
                     s.cs_level = 1'b1;
                     o.burst_done = 1'b1;
                  end else if (s.mode == MODE_RD) begin
                     s.shift_reg = '0;
                     s.bits_left = BIT_CNT_W'(BYTE_BITS);
                  end
               end
            end
         end
      endcase
      o.sclk = s.sclk_level;
      o.mosi = s.mosi_level;
      o.cs_n = s.cs_level;
      o.wants_byte = waiting_for_load(s);
      o.busy_res = (s.mode != MODE_IDLE);
      return o;
   endfunction

   function automatic req_type make_req(input cmd_type cmd, input logic [7:0] address,
                                        input logic [7:0] burst_length,
                                        input logic [7:0] wr_data, input logic miso);
      req_type r;
      r.cmd = cmd;
      r.address = address;
      r.burst_length = burst_length;
      r.wr_data = wr_data;
      r.miso = miso;
      return r;
   endfunction

   // queue a word and keep the stimulus-side model in step with it
   task automatic add_word(input req_type r);
      rsp_type ignored;
      ignored = advance_pins(stim_model, r);
      queued_requests.push_back(r);
   endtask

   // idle percentage per side, by how far the run has come
   function automatic int idle_pct(input logic receiver);
      if (words_in < total_words / 3) return receiver ? 57 : 20;
      if (words_in < 2 * total_words / 3) return receiver ? 20 : 57;
      return 0;
   endfunction

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= MAX_PRINTED)
         $display("mismatch at response word %0d (t=%0t): %s", words_out, $time, what);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // driver: new word at the falling edge once the previous one is taken
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (queued_requests.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
            next_req = queued_requests.pop_front();
            req_cmd <= next_req.cmd;
            req_address <= next_req.address;
            req_burst_length <= next_req.burst_length;
            req_wr_data <= next_req.wr_data;
            req_miso <= next_req.miso;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_used && words_in >= HOLD_AT) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else begin
         rsp_stall <= !reset && ($urandom_range(99) < idle_pct(1'b1));
      end
   end

   // monitor: predict on request accept, compare on response accept
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         pin_model = idle_state();
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            seen_req = make_req(cmd_type'(req_cmd), req_address, req_burst_length,
                                req_wr_data, req_miso);
            want_rsp = advance_pins(pin_model, seen_req);
            expected_pin_words.push_back(want_rsp);
            words_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            seen_rsp = {rsp_sclk, rsp_mosi, rsp_cs_n, rsp_rd_data, rsp_rd_valid,
                        rsp_wants_byte, rsp_busy_res, rsp_burst_done, rsp_rejected};
            if (expected_pin_words.size() == 0) begin
               report_mismatch("response word with nothing expected");
            end else begin
               want_rsp = expected_pin_words.pop_front();
               check_field("sclk", seen_rsp.sclk, want_rsp.sclk);
               check_field("mosi", seen_rsp.mosi, want_rsp.mosi);
               check_field("cs_n", seen_rsp.cs_n, want_rsp.cs_n);
               check_field("rd_data", seen_rsp.rd_data, want_rsp.rd_data);
               check_field("rd_valid", seen_rsp.rd_valid, want_rsp.rd_valid);
               check_field("wants_byte", seen_rsp.wants_byte, want_rsp.wants_byte);
               check_field("busy_res", seen_rsp.busy_res, want_rsp.busy_res);
               check_field("burst_done", seen_rsp.burst_done, want_rsp.burst_done);
               check_field("rejected", seen_rsp.rejected, want_rsp.rejected);
               bursts_seen += want_rsp.burst_done;
               reads_seen += want_rsp.rd_valid;
               rejects_seen += want_rsp.rejected;
            end
            words_out++;
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin
      req_type w;
      int roll;
      stim_model = idle_state();
      pin_model = idle_state();

      // directed: refused and ignored commands, a write start, its address byte and the load of its first data byte
      add_word(make_req(CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b1));
      add_word(make_req(CMD_LOAD, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      add_word(make_req(CMD_RD, 8'hFF, 8'd0, 8'h00, 1'b0));
      add_word(make_req(CMD_WR, 8'h00, 8'd1, 8'hFF, 1'b1));
      add_word(make_req(CMD_WR, 8'h00, 8'd2, 8'h00, 1'b0));
      add_word(make_req(CMD_RD, 8'hFF, 8'd255, 8'h00, 1'b0));
      add_word(make_req(CMD_WR, 8'h5A, 8'd0, 8'h00, 1'b1));
      add_word(make_req(CMD_LOAD, 8'h00, 8'h00, 8'hA5, 1'b1));
      for (int i = 0; i < 17; i++)
         add_word(make_req(CMD_TICK, 8'h00, 8'h00, 8'h00, i[0]));
      add_word(make_req(CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      add_word(make_req(CMD_LOAD, 8'h00, 8'h00, 8'hFF, 1'b0));

      // random: mostly well-formed bursts with random content, some noise
      while (queued_requests.size() < RANDOM_WORDS || stim_model.mode != MODE_IDLE) begin
         w = make_req(cmd_type'($urandom_range(3)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
         roll = $urandom_range(99);
         if (stim_model.mode == MODE_IDLE) begin
            if (roll < 80) begin
               w.cmd = $urandom_range(1) ? CMD_WR : CMD_RD;
               w.burst_length = ($urandom_range(19) == 0) ? 8'($urandom_range(6, 20))
                                                          : 8'($urandom_range(2, 5));
            end else if (roll < 88) begin
               w.cmd = $urandom_range(1) ? CMD_WR : CMD_RD;
               w.burst_length = 8'($urandom_range(1));
            end
         end else if (waiting_for_load(stim_model)) begin
            if (roll < 85) w.cmd = CMD_LOAD;
         end else if (roll < 88) begin
            w.cmd = CMD_TICK;
         end
         add_word(w);
      end
      total_words = queued_requests.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (words_in < total_words || expected_pin_words.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d words: %0d bursts finished, %0d read bytes, %0d starts refused",
               words_out, bursts_seen, reads_seen, rejects_seen);
      $display("mismatches: %0d", errors);
      if (errors == 0 && expected_pin_words.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/spim_pkg.sv
hw/rtl/spim_in_stage.sv
hw/rtl/spim_core.sv
hw/rtl/spim_out_stage.sv
hw/rtl/spi_master_burst_transfer_unit.sv
hw/rtl/spim_checker.sv
dv/spi_master_burst_transfer_unit_tb.sv
